// File: src/ekc_pkg.sv
// Shared types, constants and the kernel arithmetic for the 3x3 edge kernel.
// No dependencies; imported by edge_kernel_3x3_convolution.
`default_nettype none

package ekc_pkg;

    // Line storage geometry
    localparam int unsigned LINE_DEPTH  = 1024;
    localparam int unsigned LINE_AW     = $clog2(LINE_DEPTH);
    localparam int unsigned HEIGHT_MAX  = 4096;

    // Field widths
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned GRAD_W  = 11;
    localparam int unsigned ROW_W   = 12;
    localparam int unsigned COL_W   = 10;
    localparam int unsigned KSEL_W  = 2;
    localparam int unsigned WIDTH_W = 11;
    localparam int unsigned HGT_W   = 13;
    localparam int unsigned CFGI_W  = 2;
    localparam int unsigned CFGD_W  = 13;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_KERNEL_SELECT = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_IMAGE_HEIGHT  = 2'd2;

    // Kernel codes
    localparam logic [KSEL_W-1:0] KSEL_PREWITT_X = 2'd0;
    localparam logic [KSEL_W-1:0] KSEL_PREWITT_Y = 2'd1;
    localparam logic [KSEL_W-1:0] KSEL_SOBEL_X   = 2'd2;
    localparam logic [KSEL_W-1:0] KSEL_SOBEL_Y   = 2'd3;

    // Register reset values
    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HGT_W-1:0]   HEIGHT_RESET = 13'd480;

    typedef logic [PIX_W-1:0] t_pix;
    // Window taps, row-major: index 0 is top-left, 8 is bottom-right
    typedef t_pix [8:0] t_window;
    // Line memory word: upper byte is the previous row, lower byte the row before
    typedef logic [2*PIX_W-1:0] t_line_word;

    // Widen one tap to a signed working value
    function automatic logic signed [GRAD_W:0] ekc_ext(input t_pix p);
        return $signed({{(GRAD_W+1-PIX_W){1'b0}}, p});
    endfunction

    // Weighted sum of the window for the chosen kernel; centre weight is zero
    function automatic logic signed [GRAD_W-1:0] ekc_gradient(
        input logic [KSEL_W-1:0] sel,
        input t_window           w
    );
        logic signed [GRAD_W:0] pos;
        logic signed [GRAD_W:0] neg;
        logic signed [GRAD_W:0] sum;
        pos = '0;
        neg = '0;
        case (sel)
            KSEL_PREWITT_X: begin
                pos = ekc_ext(w[2]) + ekc_ext(w[5]) + ekc_ext(w[8]);
                neg = ekc_ext(w[0]) + ekc_ext(w[3]) + ekc_ext(w[6]);
            end
            KSEL_PREWITT_Y: begin
                pos = ekc_ext(w[6]) + ekc_ext(w[7]) + ekc_ext(w[8]);
                neg = ekc_ext(w[0]) + ekc_ext(w[1]) + ekc_ext(w[2]);
            end
            KSEL_SOBEL_X: begin
                pos = ekc_ext(w[2]) + (ekc_ext(w[5]) <<< 1) + ekc_ext(w[8]);
                neg = ekc_ext(w[0]) + (ekc_ext(w[3]) <<< 1) + ekc_ext(w[6]);
            end
            KSEL_SOBEL_Y: begin
                pos = ekc_ext(w[6]) + (ekc_ext(w[7]) <<< 1) + ekc_ext(w[8]);
                neg = ekc_ext(w[0]) + (ekc_ext(w[1]) <<< 1) + ekc_ext(w[2]);
            end
            default: begin
                pos = '0;
                neg = '0;
            end
        endcase
        sum = pos - neg;
        return $signed(sum[GRAD_W-1:0]);
    endfunction

endpackage

`default_nettype wire

// File: src/edge_kernel_3x3_convolution.sv
// Top level of the 3x3 edge kernel: line memory, window, counters and output register.
// Depends on ekc_pkg.
`default_nettype none

// Streaming 3x3 Prewitt/Sobel filter. Pixels arrive in raster order, one per
// transaction, and the block takes one pixel every clock while the output side
// keeps up. The pixel that completes a window passes through stage 1, which
// reads the single line memory (both earlier rows packed in one word, read and
// written back at the column address), and then the window update and kernel
// sum load the output register. Border pixels give no result, so the output
// carries (width-2)*(height-2) results per frame. There is no clearing pass
// after reset; entries of the line memory are defined once the first two rows
// have streamed past. Write the size and kernel registers only between frames
// while the block is idle.
module edge_kernel_3x3_convolution
    import ekc_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    // pixel input
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire  [PIX_W-1:0]          i_pixel,
    // result output
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic signed [GRAD_W-1:0]  o_gradient,
    output logic [ROW_W-1:0]          o_out_row,
    output logic [COL_W-1:0]          o_out_col,
    output logic                      o_frame_last,
    // configuration writes
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire  [CFGI_W-1:0]         i_cfg_index,
    input  wire  [CFGD_W-1:0]         i_cfg_data
);

    // Configuration registers
    logic [KSEL_W-1:0]  r_kernel_select;
    logic [WIDTH_W-1:0] r_image_width;
    logic [HGT_W-1:0]   r_image_height;

    // Raster position of the next incoming pixel
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;

    // Stage 1: pixel waiting for its line memory data
    logic               r_v1;
    logic               r_p1;
    logic               r_last1;
    t_pix               r_px1;
    logic [LINE_AW-1:0] r_addr1;
    logic [ROW_W-1:0]   r_orow1;
    logic [COL_W-1:0]   r_ocol1;

    // Line memory and its registered read port
    t_line_word         r_line [LINE_DEPTH];
    t_line_word         r_rd;

    // Window and output register
    t_window            r_win;
    t_window            n_win;
    logic               r_out_valid;
    logic signed [GRAD_W-1:0] r_grad;
    logic [ROW_W-1:0]   r_orow;
    logic [COL_W-1:0]   r_ocol;
    logic               r_olast;

    // Handshake and control
    logic               in_acc;
    logic               out_free;
    logic               adv1;
    logic [WIDTH_W-1:0] eff_w;
    logic [HGT_W-1:0]   eff_h;
    logic [WIDTH_W-1:0] col_ext;
    logic [HGT_W-1:0]   row_ext;
    logic               produce;
    logic               last_px;

    // Clamp the frame size to the supported range
    always_comb begin
        eff_w = r_image_width;
        if (r_image_width < WIDTH_W'(3))
            eff_w = WIDTH_W'(3);
        else if (r_image_width > WIDTH_W'(LINE_DEPTH))
            eff_w = WIDTH_W'(LINE_DEPTH);
        eff_h = r_image_height;
        if (r_image_height < HGT_W'(3))
            eff_h = HGT_W'(3);
        else if (r_image_height > HGT_W'(HEIGHT_MAX))
            eff_h = HGT_W'(HEIGHT_MAX);
    end

    // Decide whether the incoming pixel closes an interior window
    always_comb begin
        col_ext = {{(WIDTH_W-COL_W){1'b0}}, r_col};
        row_ext = {{(HGT_W-ROW_W){1'b0}}, r_row};
        produce = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2))
                  && (row_ext < eff_h) && (col_ext < eff_w);
        last_px = (row_ext == eff_h - HGT_W'(1)) && (col_ext == eff_w - WIDTH_W'(1));
    end

    // Advance the raster position, wrapping at the effective size
    always_comb begin
        n_col = r_col + COL_W'(1);
        n_row = r_row;
        if (col_ext + WIDTH_W'(1) >= eff_w) begin
            n_col = '0;
            if (row_ext + HGT_W'(1) >= eff_h)
                n_row = '0;
            else
                n_row = r_row + ROW_W'(1);
        end
    end

    // Stall stage 1 only when it holds a result and the output is full
    assign out_free = !r_out_valid || i_ready;
    assign adv1     = r_v1 && (!r_p1 || out_free);
    assign o_ready  = !r_v1 || adv1;
    assign in_acc   = i_valid && o_ready;

    // Configuration port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_select <= KSEL_PREWITT_X;
            r_image_width   <= WIDTH_RESET;
            r_image_height  <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KERNEL_SELECT: r_kernel_select <= i_cfg_data[KSEL_W-1:0];
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the raster counters; advance on each input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v1 <= 1'b0;
        else if (in_acc)
            r_v1 <= 1'b1;
        else if (adv1)
            r_v1 <= 1'b0;
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p1    <= produce;
            r_last1 <= last_px;
            r_px1   <= i_pixel;
            r_addr1 <= r_col[LINE_AW-1:0];
            r_orow1 <= r_row - ROW_W'(1);
            r_ocol1 <= r_col - COL_W'(1);
        end
    end

    // Read the line word at the new column; write back the shifted rows.
    // Consecutive pixels never share a column, so the read and the write-back
    // in one cycle always hit different entries.
    always_ff @(posedge i_clk) begin
        if (in_acc)
            r_rd <= r_line[r_col[LINE_AW-1:0]];
        if (adv1)
            r_line[r_addr1] <= {r_px1, r_rd[2*PIX_W-1:PIX_W]};
    end

    // Shift the window left and insert the new right-hand column
    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[2] = r_rd[PIX_W-1:0];
        n_win[5] = r_rd[2*PIX_W-1:PIX_W];
        n_win[8] = r_px1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_win <= '0;
        else if (adv1)
            r_win <= n_win;
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (adv1 && r_p1)
            r_out_valid <= 1'b1;
        else if (i_ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && r_p1) begin
            r_grad  <= ekc_gradient(r_kernel_select, n_win);
            r_orow  <= r_orow1;
            r_ocol  <= r_ocol1;
            r_olast <= r_last1;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_gradient   = r_grad;
    assign o_out_row    = r_orow;
    assign o_out_col    = r_ocol;
    assign o_frame_last = r_olast;

    // Read and write-back of the line memory never collide
    a_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && adv1) |-> (r_col[LINE_AW-1:0] != r_addr1))
        else $error("line memory read and write-back hit the same column");

    // A pending result blocks new pixels while the output is full
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_p1 && !out_free) |-> !o_ready)
        else $error("pixel accepted while stage 1 result is blocked");

    // An interior pixel reaches stage 1 marked to produce a result
    a_produce_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && produce) |=> (r_v1 && r_p1))
        else $error("interior pixel lost its result flag");

    // A held result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !(adv1 && r_p1))
        else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
